[src/integer_to_ascii_formatter_core_assert.svh]
// Assertion macros for the integer to ASCII formatter.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_ASSERT_SVH

// same-cycle implication
`define ITAF_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("itaf assertion failed");

// next-cycle implication
`define ITAF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("itaf assertion failed");

`endif

[src/itaf_pkg.sv]
// Package of the integer to ASCII formatter: item types, codes, constants, digit map.
package itaf_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_FIELD_DEF  = 63;

  localparam logic [1:0] RADIX_BIN = 2'd0;
  localparam logic [1:0] RADIX_OCT = 2'd1;
  localparam logic [1:0] RADIX_DEC = 2'd2;
  localparam logic [1:0] RADIX_HEX = 2'd3;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UPPER = 8'h41;
  localparam logic [7:0] CH_LOWER = 8'h61;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [3:0] TEN      = 4'd10;

  // floor(x / 10) = (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  typedef struct packed {
    logic [31:0] magnitude;
    logic        negative;
    logic [1:0]  radix;
    logic [5:0]  field_width;
    logic        left_adjust;
    logic        zero_pad;
    logic        upper_case;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } out_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ch;
    if (d < TEN) begin
      ch = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      ch = CH_UPPER + {4'd0, d} - {4'd0, TEN};
    end else begin
      ch = CH_LOWER + {4'd0, d} - {4'd0, TEN};
    end
    return ch;
  endfunction

endpackage

[src/integer_to_ascii_formatter_core.sv]
// Integer to ASCII formatter: digit extraction on a shared divide step, then field output.
// Sequence: accept in idle, then per digit a divide step (bases 2, 8, 16) or a multiply
//   by reciprocal then remainder step (base 10), then field output that holds on stalls.
// Hand-off: a new item is taken only after the last field character is loaded, which
//   comes after up to 32 digits and 63 field characters; in_stall_o stays high meanwhile.
// Reset: asynchronous active low, returns to idle with no output item pending.
`include "integer_to_ascii_formatter_core_assert.svh"

module integer_to_ascii_formatter_core #(
  parameter int VALUE_BITS = itaf_pkg::VALUE_BITS_DEF,
  parameter int MAX_FIELD  = itaf_pkg::MAX_FIELD_DEF
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  itaf_pkg::in_t   in_item_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output itaf_pkg::out_t  out_item_o
);

  localparam int IDX_W = $clog2(VALUE_BITS);
  localparam int ND_W  = $clog2(VALUE_BITS + 1);
  localparam int CNT_W = $clog2(MAX_FIELD + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIG,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [VALUE_BITS-1:0]  u_q;
  logic [63:0]            prod_q;
  logic [ND_W-1:0]        nd_q;
  logic [IDX_W-1:0]       dp_q;
  logic [CNT_W-1:0]       k_q, width_q;
  logic [1:0]             radix_q;
  logic                   neg_q, ladj_q, zpad_q, upper_q;
  logic                   out_valid_q;
  itaf_pkg::out_t         out_item_q;
  logic [3:0]             digits_q [VALUE_BITS];

  logic                   accept;
  logic                   store;
  logic [3:0]             dig;
  logic [VALUE_BITS-1:0]  u_next;
  logic [31:0]            u32, q32, q10, rem32;
  logic [CNT_W-1:0]       actual, total, pad;
  logic [CNT_W:0]         pad_p1;
  logic                   load, is_digit, is_last;
  logic [7:0]             ch;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);

  // one divide step: shift for powers of two, reciprocal product for ten
  always_comb begin
    u32   = 32'(u_q);
    q32   = 32'(prod_q[63:itaf_pkg::RECIP_SHIFT]);
    q10   = (q32 << 3) + (q32 << 1);
    rem32 = u32 - q10;
    unique case (radix_q)
      itaf_pkg::RADIX_BIN: begin
        dig    = {3'd0, u_q[0]};
        u_next = u_q >> 1;
      end
      itaf_pkg::RADIX_OCT: begin
        dig    = {1'b0, u32[2:0]};
        u_next = u_q >> 3;
      end
      itaf_pkg::RADIX_HEX: begin
        dig    = u32[3:0];
        u_next = u_q >> 4;
      end
      default: begin
        dig    = rem32[3:0];
        u_next = VALUE_BITS'(q32);
      end
    endcase
  end

  assign store = (state_q == ST_DIG);

  // field layout
  always_comb begin
    actual = CNT_W'(nd_q) + CNT_W'(neg_q);
    total  = (width_q > actual) ? width_q : actual;
    pad    = total - actual;
    pad_p1 = {1'b0, pad} + 1'b1;
    ch       = itaf_pkg::CH_SPACE;
    is_digit = 1'b0;
    priority if (ladj_q) begin
      if (neg_q && (k_q == '0)) begin
        ch = itaf_pkg::CH_MINUS;
      end else if (k_q < actual) begin
        is_digit = 1'b1;
      end else begin
        ch = itaf_pkg::CH_SPACE;
      end
    end else if (neg_q && zpad_q) begin
      if (k_q == '0) begin
        ch = itaf_pkg::CH_MINUS;
      end else if ({1'b0, k_q} < pad_p1) begin
        ch = itaf_pkg::CH_ZERO;
      end else begin
        is_digit = 1'b1;
      end
    end else begin
      if (k_q < pad) begin
        ch = zpad_q ? itaf_pkg::CH_ZERO : itaf_pkg::CH_SPACE;
      end else if (neg_q && (k_q == pad)) begin
        ch = itaf_pkg::CH_MINUS;
      end else begin
        is_digit = 1'b1;
      end
    end
    if (is_digit) begin
      ch = itaf_pkg::digit_char(digits_q[dp_q], upper_q);
    end
    is_last = (k_q == total - 1'b1);
  end

  assign load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i) begin
    if (store) begin
      digits_q[nd_q[IDX_W-1:0]] <= dig;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      u_q         <= '0;
      prod_q      <= '0;
      nd_q        <= '0;
      k_q         <= '0;
      dp_q        <= '0;
      width_q     <= '0;
      radix_q     <= '0;
      neg_q       <= 1'b0;
      ladj_q      <= 1'b0;
      zpad_q      <= 1'b0;
      upper_q     <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q          <= 1'b1;
        out_item_q.out_char  <= ch;
        out_item_q.last_char <= is_last;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            u_q     <= in_item_i.magnitude[VALUE_BITS-1:0];
            neg_q   <= in_item_i.negative;
            radix_q <= in_item_i.radix;
            ladj_q  <= in_item_i.left_adjust;
            zpad_q  <= in_item_i.zero_pad;
            upper_q <= in_item_i.upper_case;
            width_q <= (int'(in_item_i.field_width) > MAX_FIELD) ?
                       CNT_W'(MAX_FIELD) : CNT_W'(in_item_i.field_width);
            nd_q    <= '0;
            k_q     <= '0;
            state_q <= (in_item_i.radix == itaf_pkg::RADIX_DEC) ? ST_MUL : ST_DIG;
          end
        end
        ST_MUL: begin
          prod_q  <= 64'(u32) * 64'(itaf_pkg::RECIP10);
          state_q <= ST_DIG;
        end
        ST_DIG: begin
          u_q  <= u_next;
          nd_q <= nd_q + 1'b1;
          dp_q <= nd_q[IDX_W-1:0];
          if (u_next == '0) begin
            state_q <= ST_EMIT;
          end else begin
            state_q <= (radix_q == itaf_pkg::RADIX_DEC) ? ST_MUL : ST_DIG;
          end
        end
        ST_EMIT: begin
          if (load) begin
            k_q <= k_q + 1'b1;
            if (is_digit) begin
              dp_q <= dp_q - 1'b1;
            end
            if (is_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ITAF_ASSERT(a_has_digit, state_q == ST_EMIT, nd_q != '0)
  `ITAF_ASSERT(a_k_in_field, state_q == ST_EMIT, k_q < total)
  `ITAF_ASSERT_NEXT(a_last_ends, load && is_last, state_q == ST_IDLE && out_item_o.last_char)

endmodule
